// ===== rtl/core/gsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_pkg
// Shared types and constants of the fixed point orthonormal frame block.
// ----------------------------------------------------------------------------
package gsf_pkg;

    // bits of the radicand and of the root
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = RAD_W / 2;
    // one root bit per cell
    localparam int SQRT_STEPS = ROOT_W;
    // one quotient bit per cell, quotient is at most 2^30
    localparam int QUO_W      = 31;
    localparam int DIV_STEPS  = QUO_W;
    // front stages, setup stage and output stage of the normalize unit
    localparam int NORM_FRONT = 6;
    localparam int NORM_LAT   = NORM_FRONT + SQRT_STEPS + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [2:0][30:0] mg;
        logic [2:0]       neg;
        logic             zero;
    } t_sq_side;

    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        t_sq_side          side;
    } t_sqrt_data;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0]   lane;
        logic [ROOT_W-1:0] den;
        logic [2:0]        neg;
        logic              zero;
    } t_div_data;

endpackage

`default_nettype wire

// ===== rtl/core/gram_schmidt_frame_3d_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gram_schmidt_frame_3d_top
// Orthonormal frame u0, u1, u2 in Q2.30 from two Q16.16 vectors a and b.
// ----------------------------------------------------------------------------
// A fully pipelined unit: one request is taken every cycle while the output
// side keeps taking results. Most of the pipeline lies in the two normalize
// units, each a chain of 32 square root cells and 31 divider cells (one bit
// per cell) behind six range and sum of squares stages. The whole pipeline
// holds while a result waits in the output register, so the input is ready
// exactly when the output register is empty or being taken. A zero vector
// comes out as zero.
module gram_schmidt_frame_3d_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_u0_x,
    output logic [31:0]      o_u0_y,
    output logic [31:0]      o_u0_z,
    output logic [31:0]      o_u1_x,
    output logic [31:0]      o_u1_y,
    output logic [31:0]      o_u1_z,
    output logic [31:0]      o_u2_x,
    output logic [31:0]      o_u2_y,
    output logic [31:0]      o_u2_z
);

    logic             w_en;
    logic [2:0][31:0] w_a;
    logic [2:0][31:0] w_b;
    logic [2:0][63:0] w_a_mag;
    logic [2:0]       w_a_neg;

    logic [2:0][31:0] r_bdly [gsf_pkg::NORM_LAT];
    logic             w_n1_valid;
    logic [2:0][31:0] w_n1_u;

    logic             r_d1_valid;
    logic [2:0][31:0] r_d1_b;
    logic [2:0][31:0] r_d1_u0;
    logic [2:0][63:0] r_d1_p;
    logic             r_d2_valid;
    logic [2:0][31:0] r_d2_b;
    logic [2:0][31:0] r_d2_u0;
    logic [65:0]      r_d2_dot;
    logic             r_d3_valid;
    logic [2:0][31:0] r_d3_b;
    logic [2:0][31:0] r_d3_u0;
    logic [33:0]      r_d3_d;
    logic [33:0]      n_d3_d;
    logic             r_d4_valid;
    logic [2:0][31:0] r_d4_b;
    logic [2:0][31:0] r_d4_u0;
    logic [2:0][65:0] r_d4_p;

    logic [65:0]      w_r [3];
    logic [2:0][63:0] w_r_mag;
    logic [2:0]       w_r_neg;

    logic [2:0][31:0] r_udly [gsf_pkg::NORM_LAT];
    logic             w_n2_valid;
    logic [2:0][31:0] w_n2_u;

    logic             r_c1_valid;
    logic [2:0][31:0] r_c1_u0;
    logic [2:0][31:0] r_c1_u1;
    logic [5:0][63:0] r_c1_p;
    logic [5:0][63:0] n_c1_p;

    logic             r_out_valid;
    logic [2:0][31:0] r_out_u0;
    logic [2:0][31:0] r_out_u1;
    logic [2:0][31:0] r_out_u2;
    logic [2:0][31:0] n_out_u2;
    logic [64:0]      w_cx [3];
    logic [34:0]      w_cr [3];

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_a = {i_a_z, i_a_y, i_a_x};
    assign w_b = {i_b_z, i_b_y, i_b_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a_neg[i] = w_a[i][31];
            if (w_a[i][31]) begin
                w_a_mag[i] = {32'd0, 32'd0 - w_a[i]};
            end else begin
                w_a_mag[i] = {32'd0, w_a[i]};
            end
        end
    end

    // the most negative input keeps its magnitude 2^31 as unsigned
    gsf_norm u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_mag   (w_a_mag),
        .i_neg   (w_a_neg),
        .o_valid (w_n1_valid),
        .o_u     (w_n1_u)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bdly[0] <= w_b;
            for (int k = 1; k < gsf_pkg::NORM_LAT; k++) begin
                r_bdly[k] <= r_bdly[k-1];
            end
            r_udly[0] <= r_d4_u0;
            for (int k = 1; k < gsf_pkg::NORM_LAT; k++) begin
                r_udly[k] <= r_udly[k-1];
            end
        end
    end

    // projection of b on u0, rounded back to Q16.16
    assign n_d3_d = 34'(($signed(r_d2_dot) + 66'sd536870912) >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            r_d3_valid <= 1'b0;
            r_d4_valid <= 1'b0;
        end else if (w_en) begin
            r_d1_valid <= w_n1_valid;
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
            r_d4_valid <= r_d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_b  <= r_bdly[gsf_pkg::NORM_LAT-1];
            r_d1_u0 <= w_n1_u;
            for (int i = 0; i < 3; i++) begin
                r_d1_p[i] <= 64'($signed(64'($signed(r_bdly[gsf_pkg::NORM_LAT-1][i]))
                           * $signed(64'($signed(w_n1_u[i])))));
            end
            r_d2_b   <= r_d1_b;
            r_d2_u0  <= r_d1_u0;
            r_d2_dot <= 66'($signed(r_d1_p[0])) + 66'($signed(r_d1_p[1]))
                      + 66'($signed(r_d1_p[2]));
            r_d3_b   <= r_d2_b;
            r_d3_u0  <= r_d2_u0;
            r_d3_d   <= n_d3_d;
            r_d4_b   <= r_d3_b;
            r_d4_u0  <= r_d3_u0;
            for (int i = 0; i < 3; i++) begin
                r_d4_p[i] <= 66'($signed(66'($signed(r_d3_u0[i])))
                           * $signed(66'($signed(r_d3_d))));
            end
        end
    end

    // remainder b - u0 * d in Q16.46, magnitude at most 2^63
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_r[i] = {{4{r_d4_b[i][31]}}, r_d4_b[i], 30'd0} - r_d4_p[i];
            w_r_neg[i] = w_r[i][65];
            if (w_r[i][65]) begin
                w_r_mag[i] = 64'(66'd0 - w_r[i]);
            end else begin
                w_r_mag[i] = w_r[i][63:0];
            end
        end
    end

    gsf_norm u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d4_valid),
        .i_mag   (w_r_mag),
        .i_neg   (w_r_neg),
        .o_valid (w_n2_valid),
        .o_u     (w_n2_u)
    );

    // cross product terms: x uses p0 - p1, y uses p2 - p3, z uses p4 - p5
    always_comb begin
        n_c1_p[0] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][1])))
                  * $signed(64'($signed(w_n2_u[2]))));
        n_c1_p[1] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][2])))
                  * $signed(64'($signed(w_n2_u[1]))));
        n_c1_p[2] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][2])))
                  * $signed(64'($signed(w_n2_u[0]))));
        n_c1_p[3] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][0])))
                  * $signed(64'($signed(w_n2_u[2]))));
        n_c1_p[4] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][0])))
                  * $signed(64'($signed(w_n2_u[1]))));
        n_c1_p[5] = 64'($signed(64'($signed(r_udly[gsf_pkg::NORM_LAT-1][1])))
                  * $signed(64'($signed(w_n2_u[0]))));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cx[i] = 65'($signed(r_c1_p[2*i])) - 65'($signed(r_c1_p[2*i+1]));
            w_cr[i] = 35'(($signed(w_cx[i]) + 65'sd536870912) >>> 30);
            if ($signed(w_cr[i]) > 35'sd1073741824) begin
                n_out_u2[i] = 32'd1073741824;
            end else if ($signed(w_cr[i]) < -35'sd1073741824) begin
                n_out_u2[i] = 32'd0 - 32'd1073741824;
            end else begin
                n_out_u2[i] = w_cr[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_c1_valid  <= w_n2_valid;
            r_out_valid <= r_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_u0  <= r_udly[gsf_pkg::NORM_LAT-1];
            r_c1_u1  <= w_n2_u;
            r_c1_p   <= n_c1_p;
            r_out_u0 <= r_c1_u0;
            r_out_u1 <= r_c1_u1;
            r_out_u2 <= n_out_u2;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_u0_x = r_out_u0[0];
    assign o_u0_y = r_out_u0[1];
    assign o_u0_z = r_out_u0[2];
    assign o_u1_x = r_out_u1[0];
    assign o_u1_y = r_out_u1[1];
    assign o_u1_z = r_out_u1[2];
    assign o_u2_x = r_out_u2[0];
    assign o_u2_y = r_out_u2[1];
    assign o_u2_z = r_out_u2[2];

    a_u0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_u0[0]) <= 32'sd1073741824)
                     && ($signed(r_out_u0[0]) >= -32'sd1073741824)
                     && ($signed(r_out_u0[1]) <= 32'sd1073741824)
                     && ($signed(r_out_u0[1]) >= -32'sd1073741824)
                     && ($signed(r_out_u0[2]) <= 32'sd1073741824)
                     && ($signed(r_out_u0[2]) >= -32'sd1073741824))
        else $error("u0 component beyond unit range");

    a_u1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_u1[0]) <= 32'sd1073741824)
                     && ($signed(r_out_u1[0]) >= -32'sd1073741824)
                     && ($signed(r_out_u1[1]) <= 32'sd1073741824)
                     && ($signed(r_out_u1[1]) >= -32'sd1073741824)
                     && ($signed(r_out_u1[2]) <= 32'sd1073741824)
                     && ($signed(r_out_u1[2]) >= -32'sd1073741824))
        else $error("u1 component beyond unit range");

    a_u2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_u2[0]) <= 32'sd1073741824)
                     && ($signed(r_out_u2[0]) >= -32'sd1073741824)
                     && ($signed(r_out_u2[1]) <= 32'sd1073741824)
                     && ($signed(r_out_u2[1]) >= -32'sd1073741824)
                     && ($signed(r_out_u2[2]) <= 32'sd1073741824)
                     && ($signed(r_out_u2[2]) >= -32'sd1073741824))
        else $error("u2 saturation failed");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_d1_valid) && $stable(r_d4_valid) && $stable(r_c1_valid))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== rtl/core/gsf_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_sqrt_cell
// One step of the restoring square root: brings down two radicand bits and
// decides one root bit, then hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module gsf_sqrt_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire gsf_pkg::t_sqrt_data   i_d,
    output logic                       o_valid,
    output gsf_pkg::t_sqrt_data        o_d
);

    logic                 r_valid;
    gsf_pkg::t_sqrt_data  r_d;
    gsf_pkg::t_sqrt_data  n_d;
    logic [gsf_pkg::ROOT_W+3:0] w_t;
    logic [gsf_pkg::ROOT_W+3:0] w_trial;

    always_comb begin
        w_t     = {i_d.rem, i_d.rad[gsf_pkg::RAD_W-1 -: 2]};
        w_trial = {2'b00, i_d.root, 2'b01};
        n_d      = i_d;
        n_d.rad  = {i_d.rad[gsf_pkg::RAD_W-3:0], 2'b00};
        if (w_t >= w_trial) begin
            n_d.rem  = (gsf_pkg::ROOT_W+2)'(w_t - w_trial);
            n_d.root = {i_d.root[gsf_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = (gsf_pkg::ROOT_W+2)'(w_t);
            n_d.root = {i_d.root[gsf_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== rtl/core/gsf_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_div_cell
// One step of three restoring divisions by a shared divisor: brings down one
// dividend bit per lane and decides one quotient bit per lane.
// ----------------------------------------------------------------------------
module gsf_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire gsf_pkg::t_div_data  i_d,
    output logic                     o_valid,
    output gsf_pkg::t_div_data       o_d
);

    logic                r_valid;
    gsf_pkg::t_div_data  r_d;
    gsf_pkg::t_div_data  n_d;
    logic [gsf_pkg::ROOT_W:0] w_t [3];

    always_comb begin
        n_d = i_d;
        for (int i = 0; i < 3; i++) begin
            w_t[i] = {i_d.lane[i].rem, i_d.lane[i].low[gsf_pkg::QUO_W-1]};
            n_d.lane[i].low = {i_d.lane[i].low[gsf_pkg::QUO_W-2:0], 1'b0};
            if (w_t[i] >= {1'b0, i_d.den}) begin
                n_d.lane[i].rem = gsf_pkg::ROOT_W'(w_t[i] - {1'b0, i_d.den});
                n_d.lane[i].quo = {i_d.lane[i].quo[gsf_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_d.lane[i].rem = gsf_pkg::ROOT_W'(w_t[i]);
                n_d.lane[i].quo = {i_d.lane[i].quo[gsf_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== rtl/core/gsf_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_norm
// Scales a 3-vector given as magnitudes and signs to unit length in Q2.30:
// range shift, sum of squares, square root chain, then a divider chain.
// ----------------------------------------------------------------------------
module gsf_norm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2:0][63:0]  i_mag,
    input  wire logic [2:0]        i_neg,
    output logic                   o_valid,
    output logic [2:0][31:0]       o_u
);

    // stage 1: capture
    logic             r1_valid;
    logic [2:0][63:0] r1_mag;
    logic [2:0]       r1_neg;
    logic [63:0]      n1_m;
    // stage 2: largest magnitude
    logic             r2_valid;
    logic [2:0][63:0] r2_mag;
    logic [2:0]       r2_neg;
    logic [63:0]      r2_m;
    logic [6:0]       n2_bl;
    // stage 3: bit length
    logic             r3_valid;
    logic [2:0][63:0] r3_mag;
    logic [2:0]       r3_neg;
    logic [6:0]       r3_bl;
    logic             r3_zero;
    logic [2:0][30:0] n3_mg;
    // stage 4: shifted magnitudes
    logic             r4_valid;
    gsf_pkg::t_sq_side r4_side;
    logic [2:0][61:0] n4_sq;
    // stage 5: squares
    logic             r5_valid;
    gsf_pkg::t_sq_side r5_side;
    logic [2:0][61:0] r5_sq;
    // stage 6: sum of squares
    logic             r6_valid;
    gsf_pkg::t_sq_side r6_side;
    logic [63:0]      r6_s;

    logic                w_sq_v [gsf_pkg::SQRT_STEPS+1];
    gsf_pkg::t_sqrt_data w_sq   [gsf_pkg::SQRT_STEPS+1];

    logic                r7_valid;
    gsf_pkg::t_div_data  r7_d;
    gsf_pkg::t_div_data  n7_d;
    logic [61:0]         n7_x [3];

    logic                w_dv_v [gsf_pkg::DIV_STEPS+1];
    gsf_pkg::t_div_data  w_dv   [gsf_pkg::DIV_STEPS+1];

    logic                r8_valid;
    logic [2:0][31:0]    r8_u;
    logic [2:0][31:0]    n8_u;

    always_comb begin
        n1_m = r1_mag[0];
        if (r1_mag[1] > n1_m) begin
            n1_m = r1_mag[1];
        end
        if (r1_mag[2] > n1_m) begin
            n1_m = r1_mag[2];
        end
    end

    always_comb begin
        n2_bl = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (r2_m[i]) begin
                n2_bl = 7'(i + 1);
            end
        end
    end

    // bring the largest magnitude into [2^30, 2^31)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r3_bl < 7'd31) begin
                n3_mg[i] = 31'(r3_mag[i] << 6'(7'd31 - r3_bl));
            end else begin
                n3_mg[i] = 31'(r3_mag[i] >> 6'(r3_bl - 7'd31));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_sq[i] = 62'(r4_side.mg[i]) * 62'(r4_side.mg[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag       <= i_mag;
            r1_neg       <= i_neg;
            r2_mag       <= r1_mag;
            r2_neg       <= r1_neg;
            r2_m         <= n1_m;
            r3_mag       <= r2_mag;
            r3_neg       <= r2_neg;
            r3_bl        <= n2_bl;
            r3_zero      <= (r2_m == 64'd0);
            r4_side.mg   <= n3_mg;
            r4_side.neg  <= r3_neg;
            r4_side.zero <= r3_zero;
            r5_side      <= r4_side;
            r5_sq        <= n4_sq;
            r6_side      <= r5_side;
            r6_s         <= 64'(r5_sq[0]) + 64'(r5_sq[1]) + 64'(r5_sq[2]);
        end
    end

    assign w_sq_v[0]     = r6_valid;
    assign w_sq[0].rem   = '0;
    assign w_sq[0].root  = '0;
    assign w_sq[0].rad   = r6_s;
    assign w_sq[0].side  = r6_side;

    for (genvar k = 0; k < gsf_pkg::SQRT_STEPS; k++) begin : g_sqrt
        gsf_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_sq_v[k]),
            .i_d     (w_sq[k]),
            .o_valid (w_sq_v[k+1]),
            .o_d     (w_sq[k+1])
        );
    end

    // dividend is mg * 2^30 + floor(n / 2), its upper part is already below n
    always_comb begin
        n7_d.den  = w_sq[gsf_pkg::SQRT_STEPS].root;
        n7_d.neg  = w_sq[gsf_pkg::SQRT_STEPS].side.neg;
        n7_d.zero = w_sq[gsf_pkg::SQRT_STEPS].side.zero;
        for (int i = 0; i < 3; i++) begin
            n7_x[i] = {1'b0, w_sq[gsf_pkg::SQRT_STEPS].side.mg[i], 30'd0}
                    + 62'(w_sq[gsf_pkg::SQRT_STEPS].root[gsf_pkg::ROOT_W-1:1]);
            n7_d.lane[i].rem = {1'b0, n7_x[i][61:31]};
            n7_d.lane[i].low = n7_x[i][30:0];
            n7_d.lane[i].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= w_sq_v[gsf_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_d <= n7_d;
        end
    end

    assign w_dv_v[0] = r7_valid;
    assign w_dv[0]   = r7_d;

    for (genvar k = 0; k < gsf_pkg::DIV_STEPS; k++) begin : g_div
        gsf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_dv_v[k]),
            .i_d     (w_dv[k]),
            .o_valid (w_dv_v[k+1]),
            .o_d     (w_dv[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_dv[gsf_pkg::DIV_STEPS].zero) begin
                n8_u[i] = 32'd0;
            end else if (w_dv[gsf_pkg::DIV_STEPS].neg[i]) begin
                n8_u[i] = 32'd0 - {1'b0, w_dv[gsf_pkg::DIV_STEPS].lane[i].quo};
            end else begin
                n8_u[i] = {1'b0, w_dv[gsf_pkg::DIV_STEPS].lane[i].quo};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (i_en) begin
            r8_valid <= w_dv_v[gsf_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_u <= n8_u;
        end
    end

    assign o_valid = r8_valid;
    assign o_u     = r8_u;

endmodule

`default_nettype wire

// ===== verif/gram_schmidt_frame_3d_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gram_schmidt_frame_3d_top_test
// Drives pairs of Q16.16 vectors through the frame unit and checks every
// Q2.30 result, field by field and in order, against a bit-exact predictor,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module gram_schmidt_frame_3d_top_test;

    typedef struct {
        logic [31:0] a [3];
        logic [31:0] b [3];
    } t_vec_pair;

    typedef struct {
        logic [31:0] u [9];
    } t_frame;

    localparam int LATENCY = 150;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_u0_x, o_u0_y, o_u0_z, o_u1_x, o_u1_y, o_u1_z, o_u2_x, o_u2_y, o_u2_z;

    gram_schmidt_frame_3d_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_u0_x(o_u0_x), .o_u0_y(o_u0_y), .o_u0_z(o_u0_z),
        .o_u1_x(o_u1_x), .o_u1_y(o_u1_y), .o_u1_z(o_u1_z),
        .o_u2_x(o_u2_x), .o_u2_y(o_u2_y), .o_u2_z(o_u2_z)
    );

    t_vec_pair pending_q [$];
    t_frame    frame_q [$];
    int        gap_pct = 0;
    int        stall_pct = 0;
    bit        hold_off = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input longint v [3], output longint u [3]);
        longint unsigned mg [3];
        longint unsigned m, s, n, q;
        int bl;
        m = 0;
        s = 0;
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (v[i] < 0) ? 64'd0 - longint'(v[i]) : v[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return;
        end
        while (bl < 64 && (m >> bl) != 0) bl++;
        for (int i = 0; i < 3; i++) begin
            if (bl < 31) mg[i] <<= (31 - bl);
            else if (bl > 31) mg[i] >>= (bl - 31);
            s += mg[i] * mg[i];
        end
        n = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << 30) + (n >> 1)) / n;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    // floor((x + 2^29) / 2^30)
    function automatic longint round_q30(longint x);
        longint y;
        y = x + 64'sd536870912;
        return y >>> 30;
    endfunction

    function automatic longint sat_q30(longint x);
        if (x > 64'sd1073741824) return 64'sd1073741824;
        if (x < -64'sd1073741824) return -64'sd1073741824;
        return x;
    endfunction

    function automatic t_frame predict_frame(t_vec_pair p);
        longint a [3], b [3], u0 [3], u1 [3], r [3];
        longint dot, d;
        t_frame f;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(signed'(p.a[i]));
            b[i] = longint'(signed'(p.b[i]));
        end
        unit_vec(a, u0);
        for (int i = 0; i < 3; i++) dot += b[i] * u0[i];
        d = round_q30(dot);
        for (int i = 0; i < 3; i++) r[i] = b[i] * 64'sd1073741824 - u0[i] * d;
        unit_vec(r, u1);
        for (int i = 0; i < 3; i++) begin
            f.u[i] = u0[i][31:0];
            f.u[3 + i] = u1[i][31:0];
        end
        f.u[6] = 32'(sat_q30(round_q30(u0[1] * u1[2] - u0[2] * u1[1])));
        f.u[7] = 32'(sat_q30(round_q30(u0[2] * u1[0] - u0[0] * u1[2])));
        f.u[8] = 32'(sat_q30(round_q30(u0[0] * u1[1] - u0[1] * u1[0])));
        return f;
    endfunction

    task automatic add_pair(logic [31:0] ax, ay, az, bx, by, bz);
        t_vec_pair p;
        p.a[0] = ax; p.a[1] = ay; p.a[2] = az;
        p.b[0] = bx; p.b[1] = by; p.b[2] = bz;
        pending_q.insert(pending_q.size(), p);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 200)) - 100);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_q.size() != 0 && !hold_off && $urandom_range(1, 100) > gap_pct) begin
                t_vec_pair p;
                p = pending_q.pop_front();
                frame_q.insert(frame_q.size(), predict_frame(p));
                i_a_x <= p.a[0]; i_a_y <= p.a[1]; i_a_z <= p.a[2];
                i_b_x <= p.b[0]; i_b_y <= p.b[1]; i_b_z <= p.b[2];
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                logic [31:0] got [9];
                t_frame exp_f;
                got = '{o_u0_x, o_u0_y, o_u0_z, o_u1_x, o_u1_y, o_u1_z,
                        o_u2_x, o_u2_y, o_u2_z};
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got[0]);
                end else begin
                    exp_f = frame_q.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (got[i] !== exp_f.u[i]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %h, got %h",
                                         i, exp_f.u[i], got[i]);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0 || frame_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, zero vectors, parallel and orthogonal pairs
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        add_pair(32'h0001_0000, 0, 0, 0, 0, 0);
        add_pair(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
        add_pair(32'h0001_0000, 32'h0001_0000, 0, 32'h0002_0000, 32'h0002_0000, 0);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pair(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
        add_pair(1, 0, 0, 0, 1, 0);
        add_pair(32'hffff_ffff, 1, 32'hffff_ffff, 1, 1, 1);
        add_pair(0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 5);
        add_pair(32'h0003_0000, 32'hfffc_0000, 0, 32'h0006_0000, 32'hfff8_0000, 0);
        add_pair(32'h1234_5678, 32'hedcb_a987, 32'h0bad_f00d,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 35) : 0;
            stall_pct = (ph == 2) ? 61 : ((ph == 3) ? 35 : 0);
            for (int k = 0; k < 112; k++) begin
                logic [31:0] ax, ay, az, s;
                ax = rand_comp(); ay = rand_comp(); az = rand_comp();
                if ($urandom_range(0, 7) == 0) begin
                    // near parallel: b is a scaled copy plus a tiny offset
                    s = $urandom_range(0, 3);
                    add_pair(ax, ay, az, (ax >>> s) + $urandom_range(0, 2),
                             ay >>> s, az >>> s);
                end else begin
                    add_pair(ax, ay, az, rand_comp(), rand_comp(), rand_comp());
                end
            end
            if (ph == 1) begin
                // hold the sender until the pipeline has emptied
                while (pending_q.size() > 50) @(posedge i_clk);
                hold_off = 1;
                while (frame_q.size() != 0) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end

        repeat (LATENCY) @(posedge i_clk);
        if (mismatches == 0 && frame_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gsf_pkg.sv
rtl/core/gsf_sqrt_cell.sv
rtl/core/gsf_div_cell.sv
rtl/core/gsf_norm.sv
rtl/core/gram_schmidt_frame_3d_top.sv
verif/gram_schmidt_frame_3d_top_test.sv
